[hdl/two_table_hash_store_defines.svh]
// Assertion macros for the hash store RTL.
// Needs clk and rst_n in scope where the macros are used.
`ifndef TWO_TABLE_HASH_STORE_DEFINES_SVH
`define TWO_TABLE_HASH_STORE_DEFINES_SVH

// same-cycle implication, off during reset
`define TTHS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define TTHS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/tths_pkg.sv]
// Types, constants and hash helpers for the two-table hash store.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tths_pkg;

    localparam int TABLE_SIZE = 16;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int KEY_W      = 31;
    localparam int SLOT_W     = 4;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [KEY_W-1:0] key_t;

    typedef enum logic [1:0] {
        ACT_SEARCH = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_DELETE = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        MARK_EMPTY = 2'd0,
        MARK_OCC   = 2'd1,
        MARK_EXCL  = 2'd2
    } mark_t;

    typedef enum logic [1:0] {
        FOUND_NONE   = 2'd0,
        FOUND_FIRST  = 2'd1,
        FOUND_SECOND = 2'd2
    } found_t;

    typedef struct packed {
        idx_t p1;
        idx_t p2;
    } hash_t;

    typedef struct packed {
        found_t              found;
        logic [SLOT_W-1:0]   slot;
        logic                inserted;
    } result_t;

    // elaboration-time entry of the second-slot table: floor(TABLE_SIZE * r / 10)
    function automatic idx_t slot2_at(int r);
        return idx_t'((TABLE_SIZE * r) / 10);
    endfunction

    // indexed by (9*key) mod 10; codes above 9 never occur
    localparam idx_t SLOT2_LUT [16] = '{
        slot2_at(0), slot2_at(1), slot2_at(2), slot2_at(3),
        slot2_at(4), slot2_at(5), slot2_at(6), slot2_at(7),
        slot2_at(8), slot2_at(9), idx_t'(0), idx_t'(0),
        idx_t'(0), idx_t'(0), idx_t'(0), idx_t'(0)
    };

    // key mod 5: 16 == 1 mod 5, so fold hex digits
    function automatic logic [2:0] key_mod5(key_t k);
        logic [31:0] kx;
        logic [6:0]  s1;
        logic [4:0]  s2;
        logic [4:0]  s3;
        logic [4:0]  r;
        kx = {1'b0, k};
        s1 = '0;
        for (int i = 0; i < 8; i++) begin
            s1 = s1 + 7'(kx[4*i +: 4]);
        end
        s2 = 5'(s1[6:4]) + 5'(s1[3:0]);
        s3 = 5'(s2[4]) + 5'(s2[3:0]);
        if (s3 >= 5'd15)
            r = s3 - 5'd15;
        else if (s3 >= 5'd10)
            r = s3 - 5'd10;
        else if (s3 >= 5'd5)
            r = s3 - 5'd5;
        else
            r = s3;
        return r[2:0];
    endfunction

endpackage

`default_nettype wire

[hdl/two_table_hash_store.sv]
// Two-table hash store: search, insert (one displacement) and delete on 31-bit keys.
// Depends on tths_pkg, tths_hash and tths_core.
`timescale 1ns / 1ps
`default_nettype none

// One word is accepted per clock while in_ready is high, and each gives exactly one
// result word. A word is hashed on the way into the input register; all table reads,
// the insert/delete update and the result are done while it is held there, and the
// result enters the output register as the word advances. Table updates land at the
// same edge as the result, so the following word always sees them. The output
// register frees the input side while a result waits; throughput is one word per
// cycle as long as out_ready stays high. After reset all tables read as empty.
module two_table_hash_store (
    input  var logic        clk,
    input  var logic        rst_n,
    input  var logic        in_valid,
    output logic            in_ready,
    input  var logic [1:0]  action,
    input  var logic [30:0] key,
    output logic            out_valid,
    input  var logic        out_ready,
    output logic [1:0]      found_in,
    output logic [3:0]      slot,
    output logic            inserted
);

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic [1:0]           s1_action_reg;
    tths_pkg::key_t       s1_key_reg;
    tths_pkg::hash_t      s1_hash_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    tths_pkg::result_t    out_res_reg;

    tths_pkg::hash_t      in_hash;
    tths_pkg::result_t    core_res;
    logic                 advance;
    logic                 in_take;

    tths_hash u_hash (
        .key  (key),
        .hash (in_hash)
    );

    tths_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (advance),
        .action (s1_action_reg),
        .key    (s1_key_reg),
        .hash   (s1_hash_reg),
        .result (core_res)
    );

    always_comb
    begin
        advance  = s1_valid_reg && (!out_valid_reg || out_ready);
        in_ready = !s1_valid_reg || advance;
        in_take  = in_valid && in_ready;

        if (in_take)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_action_reg <= action;
            s1_key_reg    <= key;
            s1_hash_reg   <= in_hash;
        end
        if (advance)
            out_res_reg <= core_res;
    end

    assign out_valid = out_valid_reg;
    assign found_in  = out_res_reg.found;
    assign slot      = out_res_reg.slot;
    assign inserted  = out_res_reg.inserted;

endmodule

`default_nettype wire

[hdl/tths_hash.sv]
// Slot hashes of one key: key mod size and the second-table slot.
// Depends on tths_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tths_hash (
    input  var tths_pkg::key_t  key,
    output tths_pkg::hash_t     hash
);

    logic [2:0] m5;
    logic [3:0] r10;
    logic [3:0] r9;

    always_comb
    begin
        m5 = tths_pkg::key_mod5(key);
        // CRT: pick the residue mod 10 whose parity matches the key
        if (m5[0] == key[0])
            r10 = 4'(m5);
        else
            r10 = 4'(m5) + 4'd5;
        // (9*k) mod 10 == (-k) mod 10
        if (r10 == 4'd0)
            r9 = 4'd0;
        else
            r9 = 4'd10 - r10;
        hash.p1 = key[tths_pkg::IDX_W-1:0];
        hash.p2 = tths_pkg::SLOT2_LUT[r9];
    end

endmodule

`default_nettype wire

[hdl/tths_core.sv]
// Key tables with lookup, insert with one displacement, and delete.
// Depends on tths_pkg and two_table_hash_store_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "two_table_hash_store_defines.svh"

module tths_core (
    input  var logic              clk,
    input  var logic              rst_n,
    input  var logic              go,
    input  var logic [1:0]        action,
    input  var tths_pkg::key_t    key,
    input  var tths_pkg::hash_t   hash,
    output tths_pkg::result_t     result
);

    tths_pkg::key_t  first_keys_reg  [tths_pkg::TABLE_SIZE];
    tths_pkg::idx_t  first_slot2_reg [tths_pkg::TABLE_SIZE];  // second slot of resident key
    tths_pkg::mark_t first_marks_reg [tths_pkg::TABLE_SIZE];
    tths_pkg::key_t  second_keys_reg [tths_pkg::TABLE_SIZE];
    logic [tths_pkg::TABLE_SIZE-1:0] second_full_reg;

    tths_pkg::mark_t mark;
    tths_pkg::key_t  old_key;
    tths_pkg::idx_t  old_p2;
    logic            hit1;
    logic            hit2;
    logic            first_we;
    logic            mark_we;
    tths_pkg::mark_t mark_wdata;
    logic            move_we;
    logic            clr_second;
    logic            ins;

    always_comb
    begin
        mark    = first_marks_reg[hash.p1];
        old_key = first_keys_reg[hash.p1];
        old_p2  = first_slot2_reg[hash.p1];
        hit1    = (mark == tths_pkg::MARK_OCC) && (old_key == key);
        hit2    = (mark != tths_pkg::MARK_EMPTY) && !hit1 && second_full_reg[hash.p2]
                  && (second_keys_reg[hash.p2] == key);

        first_we   = 1'b0;
        mark_we    = 1'b0;
        mark_wdata = tths_pkg::MARK_OCC;
        move_we    = 1'b0;
        clr_second = 1'b0;
        ins        = 1'b0;
        if (action == tths_pkg::ACT_INSERT)
        begin
            if (mark != tths_pkg::MARK_OCC)
            begin
                first_we = 1'b1;
                mark_we  = 1'b1;
                ins      = 1'b1;
            end
            else if ((old_key != key) && !second_full_reg[old_p2])
            begin
                first_we = 1'b1;
                move_we  = 1'b1;
                ins      = 1'b1;
            end
        end
        else if (action == tths_pkg::ACT_DELETE)
        begin
            if (hit2)
                clr_second = 1'b1;
            else if (hit1)
            begin
                mark_we    = 1'b1;
                mark_wdata = tths_pkg::MARK_EXCL;
            end
        end

        if (hit1)
        begin
            result.found = tths_pkg::FOUND_FIRST;
            result.slot  = tths_pkg::SLOT_W'(hash.p1);
        end
        else if (hit2)
        begin
            result.found = tths_pkg::FOUND_SECOND;
            result.slot  = tths_pkg::SLOT_W'(hash.p2);
        end
        else
        begin
            result.found = tths_pkg::FOUND_NONE;
            result.slot  = '0;
        end
        result.inserted = ins;
    end

    // key storage, no reset: entries are read only behind a mark or full bit
    always_ff @(posedge clk)
    begin
        if (go && first_we)
        begin
            first_keys_reg[hash.p1]  <= key;
            first_slot2_reg[hash.p1] <= hash.p2;
        end
        if (go && move_we)
            second_keys_reg[old_p2] <= old_key;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tths_pkg::TABLE_SIZE; i++)
            begin
                first_marks_reg[i] <= tths_pkg::MARK_EMPTY;
            end
            second_full_reg <= '0;
        end
        else if (go)
        begin
            if (mark_we)
                first_marks_reg[hash.p1] <= mark_wdata;
            if (move_we)
                second_full_reg[old_p2] <= 1'b1;
            if (clr_second)
                second_full_reg[hash.p2] <= 1'b0;
        end
    end

    `TTHS_ASSERT_NEXT(a_ins_lands, go && ins,
        (first_marks_reg[$past(hash.p1)] == tths_pkg::MARK_OCC)
        && (first_keys_reg[$past(hash.p1)] == $past(key)),
        "insert did not leave key in first slot")

    `TTHS_ASSERT_NEXT(a_del_second, go && clr_second,
        !second_full_reg[$past(hash.p2)],
        "second-table delete left slot full")

    `TTHS_ASSERT_NOW(a_no_dup_ins, go && ins,
        result.found != tths_pkg::FOUND_FIRST,
        "key already in first slot was inserted again")

endmodule

`default_nettype wire
